>>> rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and codes for the flow connection tracker.
// ----------------------------------------------------------------------------
package fct_pkg;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        REQ_INGEST = 2'd0,
        REQ_SWEEP  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [2:0] {
        STS_UPDATED    = 3'd0,
        STS_CREATED    = 3'd1,
        STS_FULL       = 3'd2,
        STS_READ_VALID = 3'd3,
        STS_READ_EMPTY = 3'd4,
        STS_SWEEP_DONE = 3'd5
    } status_t;

    localparam logic [1:0] CONN_NEW     = 2'd0;
    localparam logic [1:0] CONN_EST     = 2'd1;
    localparam logic [1:0] CONN_CLOSING = 2'd2;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam int unsigned FLAG_SYN_BIT = 1;
    localparam int unsigned FLAG_ACK_BIT = 4;
    localparam int unsigned FLAG_FIN_BIT = 0;

    localparam logic [31:0] TIMEOUT_RESET = 32'd300;

    // One flow table entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] latest_time;
        logic [31:0] first_time;
        logic [47:0] rev_bytes;
        logic [47:0] fwd_bytes;
        logic [31:0] rev_packets;
        logic [31:0] fwd_packets;
        logic [47:0] key_rest;
        logic [63:0] key_addrs;
        logic [1:0]  conn_state;
    } entry_t;

    // Result item: the status code and slot or count ahead of the entry.
    typedef struct packed {
        entry_t      entry;
        logic [6:0]  slot_or_count;
        status_t     status;
    } result_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_UPDATE,
        FSM_SWEEP_END,
        FSM_READ
    } fsm_state_t;

endpackage

>>> rtl/flow_connection_tracker.sv
// ----------------------------------------------------------------------------
// flow_connection_tracker
// Flow table with key lookup, allocation, counters, idle sweep and slot read.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Content
// s_*       in         s_tvalid / s_tready       request item (tuser = kind)
// m_*       out        m_tvalid / m_tready       result item (tuser = status)
// APB       in         psel & penable & pwrite   idle_timeout at byte 0
//
// Entries sit in one synchronous memory with a registered read; valid bits are flops.
// Ingest and sweep walk one slot per cycle; an ingest that finds its key in a slot
// stops the walk at that slot. A read fetches its slot from the memory on acceptance.
// The next item is accepted in the cycle after its result loads, while that result
// may still wait in the output register. Reset clears the valid bits and sets the timeout
// to TIMEOUT_RESET; a new result stalls only while the previous one waits for m_tready.
// ----------------------------------------------------------------------------
module flow_connection_tracker #(
    parameter int FLOW_SLOTS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // Request item.
    input  logic         s_tvalid,
    output logic         s_tready,
    // iface_id[7:0], proto_num[15:8], src_addr[47:16], dst_addr[79:48],
    // src_port_num[95:80], dst_port_num[111:96], flag_bits[119:112],
    // packet_len[135:120], time_now[167:136], read_index[173:168], zero pad
    input  logic [175:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    // Result item.
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot_or_count[6:0], conn_state[8:7], key_addrs[72:9], key_rest[120:73],
    // fwd_packets[152:121], rev_packets[184:153], fwd_bytes[232:185],
    // rev_bytes[280:233], first_time[312:281], latest_time[344:313], zero pad
    output logic [351:0] m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    // Configuration.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int CW = $clog2(FLOW_SLOTS + 1);
    localparam logic [CW-1:0] SLOT_COUNT = CW'(FLOW_SLOTS);

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [31:0] idle_timeout_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : idle_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= fct_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            idle_timeout_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Input field split.
    // ------------------------------------------------------------------
    logic [63:0] in_key_addrs;
    logic [47:0] in_key_rest;
    logic [5:0]  in_read_index;

    // Addresses and the rest of the key as they are stored in an entry.
    assign in_key_addrs  = {s_tdata[47:16], s_tdata[79:48]};
    assign in_key_rest   = {s_tdata[7:0], s_tdata[15:8], s_tdata[95:80], s_tdata[111:96]};
    assign in_read_index = s_tdata[173:168];

    // Captured request.
    fct_pkg::req_type_t req_reg;
    logic [63:0]        ka_reg;
    logic [47:0]        kr_reg;
    logic [7:0]         flags_reg;
    logic [15:0]        len_reg;
    logic [31:0]        now_reg;
    logic [5:0]         rindex_reg;

    // ------------------------------------------------------------------
    // Entry memory and valid bits.
    // ------------------------------------------------------------------
    fct_pkg::entry_t    mem [FLOW_SLOTS];
    fct_pkg::entry_t    rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    fct_pkg::entry_t    wr_data;
    logic [FLOW_SLOTS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------
    fct_pkg::fsm_state_t state_reg, state_next;
    logic [CW-1:0] scan_cnt_reg;
    logic          cmp_valid_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          hit_reg;
    logic          free_found_reg;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] free_reg;
    logic [CW-1:0] freed_reg;
    fct_pkg::entry_t entry_reg;
    logic          out_valid_reg;
    fct_pkg::result_t out_reg;

    logic          accept;
    logic          issue;
    logic          scan_done;
    logic          cmp_slot_valid;
    logic          key_match;
    logic          expired;
    logic          can_emit;
    logic          full;
    logic          read_in_range;
    logic [AW-1:0] read_addr;
    logic [AW-1:0] rindex_addr;

    assign accept    = s_tvalid && s_tready;
    assign issue     = (scan_cnt_reg < SLOT_COUNT);
    assign scan_done = !issue && !cmp_valid_reg;
    assign can_emit  = !out_valid_reg || m_tready;
    assign full      = !hit_reg && !free_found_reg;

    assign cmp_slot_valid = valid_reg[cmp_idx_reg];
    assign key_match = (rd_data_reg.key_addrs == ka_reg) && (rd_data_reg.key_rest == kr_reg);
    // Idle time is zero when the clock reads earlier than the last-seen time.
    assign expired = (now_reg > rd_data_reg.latest_time)
                  && ((now_reg - rd_data_reg.latest_time) > idle_timeout_reg);

    assign read_addr     = AW'({{AW{1'b0}}, in_read_index});
    assign rindex_addr   = AW'({{AW{1'b0}}, rindex_reg});
    assign read_in_range = (32'(rindex_reg) < 32'(FLOW_SLOTS));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fct_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    case (fct_pkg::req_type_t'(s_tuser))
                        fct_pkg::REQ_INGEST: state_next = fct_pkg::FSM_SCAN;
                        fct_pkg::REQ_SWEEP:  state_next = fct_pkg::FSM_SCAN;
                        fct_pkg::REQ_READ:   state_next = fct_pkg::FSM_READ;
                        default:             state_next = fct_pkg::FSM_IDLE;
                    endcase
                end
            end
            fct_pkg::FSM_SCAN:
            begin
                if (req_reg == fct_pkg::REQ_INGEST && cmp_valid_reg && cmp_slot_valid
                    && key_match)
                begin
                    state_next = fct_pkg::FSM_UPDATE;
                end
                else if (scan_done)
                begin
                    state_next = (req_reg == fct_pkg::REQ_INGEST) ?
                                 fct_pkg::FSM_UPDATE : fct_pkg::FSM_SWEEP_END;
                end
            end
            fct_pkg::FSM_UPDATE,
            fct_pkg::FSM_SWEEP_END,
            fct_pkg::FSM_READ:
            begin
                if (can_emit)
                begin
                    state_next = fct_pkg::FSM_IDLE;
                end
            end
            default: state_next = fct_pkg::FSM_IDLE;
        endcase
    end

    // Ingest update of the selected entry.
    fct_pkg::entry_t base_entry;
    fct_pkg::entry_t upd_entry;
    logic            dir_fwd;
    logic [48:0]     byte_sum;

    always_comb
    begin
        if (hit_reg)
        begin
            base_entry = entry_reg;
        end
        else
        begin
            base_entry            = '0;
            base_entry.key_addrs  = ka_reg;
            base_entry.key_rest   = kr_reg;
            base_entry.conn_state = fct_pkg::CONN_NEW;
            base_entry.first_time = now_reg;
        end

        dir_fwd = (ka_reg[63:32] < ka_reg[31:0])
               || ((ka_reg[63:32] == ka_reg[31:0]) && (kr_reg[31:16] < kr_reg[15:0]));

        upd_entry             = base_entry;
        upd_entry.latest_time = now_reg;
        if (dir_fwd)
        begin
            byte_sum = {1'b0, base_entry.fwd_bytes} + {33'd0, len_reg};
            upd_entry.fwd_bytes = byte_sum[48] ? {48{1'b1}} : byte_sum[47:0];
            if (base_entry.fwd_packets != {32{1'b1}})
            begin
                upd_entry.fwd_packets = base_entry.fwd_packets + 32'd1;
            end
        end
        else
        begin
            byte_sum = {1'b0, base_entry.rev_bytes} + {33'd0, len_reg};
            upd_entry.rev_bytes = byte_sum[48] ? {48{1'b1}} : byte_sum[47:0];
            if (base_entry.rev_packets != {32{1'b1}})
            begin
                upd_entry.rev_packets = base_entry.rev_packets + 32'd1;
            end
        end

        if (kr_reg[39:32] == fct_pkg::PROTO_TCP)
        begin
            if (flags_reg[fct_pkg::FLAG_SYN_BIT])
            begin
                upd_entry.conn_state = fct_pkg::CONN_NEW;
            end
            else if (flags_reg[fct_pkg::FLAG_ACK_BIT])
            begin
                if (base_entry.conn_state == fct_pkg::CONN_NEW)
                begin
                    upd_entry.conn_state = fct_pkg::CONN_EST;
                end
            end
            else if (flags_reg[fct_pkg::FLAG_FIN_BIT])
            begin
                upd_entry.conn_state = fct_pkg::CONN_CLOSING;
            end
        end
        else if (base_entry.conn_state == fct_pkg::CONN_NEW)
        begin
            upd_entry.conn_state = fct_pkg::CONN_EST;
        end
    end

    // Outputs of the sequencer: memory control and the result to load.
    logic             res_load;
    fct_pkg::result_t res_next;
    logic [AW-1:0]    upd_slot;

    assign upd_slot = hit_reg ? slot_reg : free_reg;

    always_comb
    begin
        s_tready = (state_reg == fct_pkg::FSM_IDLE);
        rd_en    = 1'b0;
        rd_addr  = scan_cnt_reg[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = upd_slot;
        wr_data  = upd_entry;
        res_load = 1'b0;
        res_next = '0;
        case (state_reg)
            fct_pkg::FSM_IDLE:
            begin
                if (accept && fct_pkg::req_type_t'(s_tuser) == fct_pkg::REQ_READ)
                begin
                    rd_en   = 1'b1;
                    rd_addr = read_addr;
                end
            end
            fct_pkg::FSM_SCAN:
            begin
                rd_en = issue;
            end
            fct_pkg::FSM_UPDATE:
            begin
                res_load = can_emit;
                if (full)
                begin
                    res_next.status          = fct_pkg::STS_FULL;
                    res_next.entry.key_addrs = ka_reg;
                    res_next.entry.key_rest  = kr_reg;
                end
                else
                begin
                    wr_en                  = can_emit;
                    res_next.status        = hit_reg ? fct_pkg::STS_UPDATED
                                                     : fct_pkg::STS_CREATED;
                    res_next.slot_or_count = 7'({7'd0, upd_slot});
                    res_next.entry         = upd_entry;
                end
            end
            fct_pkg::FSM_SWEEP_END:
            begin
                res_load               = can_emit;
                res_next.status        = fct_pkg::STS_SWEEP_DONE;
                res_next.slot_or_count = 7'({7'd0, freed_reg});
            end
            fct_pkg::FSM_READ:
            begin
                res_load = can_emit;
                if (read_in_range && valid_reg[rindex_addr])
                begin
                    res_next.status        = fct_pkg::STS_READ_VALID;
                    res_next.slot_or_count = {1'b0, rindex_reg};
                    res_next.entry         = rd_data_reg;
                end
                else
                begin
                    res_next.status        = fct_pkg::STS_READ_EMPTY;
                    res_next.slot_or_count = {1'b0, rindex_reg};
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fct_pkg::FSM_IDLE;
            valid_reg      <= '0;
            scan_cnt_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            freed_reg      <= '0;
            out_valid_reg  <= 1'b0;
            req_reg        <= fct_pkg::REQ_NONE;
        end
        else
        begin
            state_reg <= state_next;

            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                req_reg        <= fct_pkg::req_type_t'(s_tuser);
                scan_cnt_reg   <= '0;
                cmp_valid_reg  <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                freed_reg      <= '0;
            end
            else if (state_reg == fct_pkg::FSM_SCAN)
            begin
                cmp_valid_reg <= issue;
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (req_reg == fct_pkg::REQ_INGEST)
                    begin
                        if (cmp_slot_valid && key_match)
                        begin
                            hit_reg <= 1'b1;
                        end
                        else if (!cmp_slot_valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                        end
                    end
                    else if (cmp_slot_valid && expired)
                    begin
                        valid_reg[cmp_idx_reg] <= 1'b0;
                        freed_reg              <= freed_reg + CW'(1);
                    end
                end
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ka_reg     <= in_key_addrs;
            kr_reg     <= in_key_rest;
            flags_reg  <= s_tdata[119:112];
            len_reg    <= s_tdata[135:120];
            now_reg    <= s_tdata[167:136];
            rindex_reg <= in_read_index;
        end
        if (state_reg == fct_pkg::FSM_SCAN)
        begin
            cmp_idx_reg <= scan_cnt_reg[AW-1:0];
            if (cmp_valid_reg && req_reg == fct_pkg::REQ_INGEST)
            begin
                if (cmp_slot_valid && key_match)
                begin
                    slot_reg  <= cmp_idx_reg;
                    entry_reg <= rd_data_reg;
                end
                else if (!cmp_slot_valid && !free_found_reg)
                begin
                    free_reg <= cmp_idx_reg;
                end
            end
        end
        if (res_load)
        begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0,
                       out_reg.entry.latest_time,
                       out_reg.entry.first_time,
                       out_reg.entry.rev_bytes,
                       out_reg.entry.fwd_bytes,
                       out_reg.entry.rev_packets,
                       out_reg.entry.fwd_packets,
                       out_reg.entry.key_rest,
                       out_reg.entry.key_addrs,
                       out_reg.entry.conn_state,
                       out_reg.slot_or_count};

endmodule

>>> rtl/fct_checker.sv
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks for the flow connection tracker.
// ----------------------------------------------------------------------------
module fct_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [351:0] m_tdata,
    input logic [2:0]   m_tuser
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A dropped packet reports no slot, state, counters or times.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == fct_pkg::STS_FULL |->
            m_tdata[8:0] == 9'd0 && m_tdata[344:121] == '0)
        else $error("table full result carries entry data");

    // A sweep result carries only the freed count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == fct_pkg::STS_SWEEP_DONE |-> m_tdata[351:7] == '0)
        else $error("sweep result carries entry data");

    // A read of an empty slot carries only the index.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == fct_pkg::STS_READ_EMPTY |->
            m_tdata[6] == 1'b0 && m_tdata[351:7] == '0)
        else $error("empty read carries entry data");

endmodule

bind flow_connection_tracker fct_checker u_fct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
